@@ hdl/stp_pkg.sv @@
`timescale 1ns / 1ps
package stp_pkg;

   // request operation codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_ABS  = 2'd1;
   localparam logic [1:0] OP_REL  = 2'd2;
   localparam logic [1:0] OP_ZERO = 2'd3;

   // motion phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_ACCEL  = 2'd1;
   localparam logic [1:0] PH_CRUISE = 2'd2;
   localparam logic [1:0] PH_DECEL  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_STEP_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_ACCELERATION = 2'd1;
   localparam logic [1:0] CSR_INVERT       = 2'd2;

   localparam logic [23:0] STEP_LENGTH_RST  = 24'd209715;
   localparam logic [31:0] ACCELERATION_RST = 32'd256000;
   localparam logic [19:0] US_PER_S         = 20'd1000000;

   localparam int POSITION_WIDTH_DEF = 32;

   typedef struct packed {
      logic accept;
      logic exec;
      logic mul;
      logic sqrt_start;
      logic mul2;
      logic div_start;
      logic commit;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       due;
      logic       go;
      logic [1:0] branch;
      logic       sqrt_busy;
      logic       div_busy;
   } status_type;

endpackage

@@ hdl/stp_sqrt.sv @@
`timescale 1ns / 1ps
module stp_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);

   logic [63:0] x_ff, r_ff, bit_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] trial;
   logic        ge;

   assign trial = r_ff + bit_ff;
   assign ge    = x_ff >= trial;
   assign busy  = cnt_ff != 6'd0;
   assign root  = r_ff[31:0];

   // count one result bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else if (start) begin
         cnt_ff <= 6'd32;
      end else if (busy) begin
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   // restore-free digit by digit root
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= radicand;
         r_ff   <= 64'd0;
         bit_ff <= 64'd1 << 62;
      end else if (busy) begin
         if (ge) begin
            x_ff <= x_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

@@ hdl/stp_div.sv @@
`timescale 1ns / 1ps
module stp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);

   logic [64:0] rem_ff;
   logic [63:0] quo_ff, den_ff;
   logic [6:0]  cnt_ff;
   logic [64:0] shifted;
   logic        ge;

   assign shifted  = {rem_ff[63:0], quo_ff[63]};
   assign ge       = shifted >= {1'b0, den_ff};
   assign busy     = cnt_ff != 7'd0;
   assign quotient = quo_ff;

   // one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd0;
      end else if (start) begin
         cnt_ff <= 7'd64;
      end else if (busy) begin
         cnt_ff <= cnt_ff - 7'd1;
      end
   end

   // shift, compare, subtract
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 65'd0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy) begin
         rem_ff <= ge ? (shifted - {1'b0, den_ff}) : shifted;
         quo_ff <= {quo_ff[62:0], ge};
      end
   end

endmodule

@@ hdl/stp_dp.sv @@
`timescale 1ns / 1ps
module stp_dp #(
   parameter int POSITION_WIDTH = stp_pkg::POSITION_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  stp_pkg::cmd_type    cmd,
   output stp_pkg::status_type status,
   input  logic [1:0]          req_op,
   input  logic signed [31:0]  req_step_target,
   input  logic [23:0]         req_start_velocity,
   input  logic [23:0]         req_end_velocity,
   input  logic [23:0]         req_peak_velocity,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic                rsp_step_pulse,
   output logic                rsp_dir_level,
   output logic signed [31:0]  rsp_position,
   output logic                rsp_moving,
   output logic [1:0]          rsp_phase
);

   localparam int PW = POSITION_WIDTH;

   // configuration
   logic [23:0] len_ff;
   logic [31:0] acc_ff;
   logic        inv_ff;

   // motion state
   logic [PW-1:0] pos_ff, tgt_ff;
   logic          neg_ff, dir_ff, pulse_ff;
   logic [31:0]   time_ff, nst_ff, decel_ff;
   logic [23:0]   vel_ff, cruise_ff;
   logic [1:0]    brn_ff;

   // latched request
   logic [1:0]    op_ff;
   logic [PW-1:0] rtgt_ff;
   logic [23:0]   sv_ff, ev_ff, pk_ff;

   // products
   logic [47:0] p1_ff;
   logic [55:0] p2_ff;
   logic [43:0] p3_ff;
   logic [51:0] p4_ff;

   // output register
   logic          o_pulse_ff, o_dir_ff, o_moving_ff;
   logic [PW-1:0] o_pos_ff;
   logic [1:0]    o_phase_ff;

   logic [31:0]   eff_acc;
   logic [23:0]   eff_len, eff_pk;
   logic [PW-1:0] diff_pos, rem, move_tgt, move_d;
   logic [31:0]   rem32, time_n, since;
   logic          due;
   logic [1:0]    cur_phase;
   logic [23:0]   vdiff, vsq_op;
   logic [55:0]   base;
   logic [48:0]   term;
   logic [63:0]   radicand;
   logic [31:0]   root, num;
   logic [63:0]   dividend, divisor, quotient;
   logic [31:0]   q_sat;
   logic          sqrt_busy, div_busy;

   assign eff_acc = (acc_ff == 32'd0) ? 32'd1 : acc_ff;
   assign eff_len = (len_ff == 24'd0) ? 24'd1 : len_ff;
   assign eff_pk  = (cruise_ff == 24'd0) ? 24'd1 : cruise_ff;

   // remaining steps and step due check
   assign diff_pos  = tgt_ff - pos_ff;
   assign rem       = diff_pos[PW-1] ? (PW'(0) - diff_pos) : diff_pos;
   assign rem32     = 32'(rem);
   assign time_n    = time_ff + 32'd1;
   assign since     = time_n - nst_ff;
   assign due       = (rem != PW'(0)) && !since[31];
   assign move_tgt  = (op_ff == stp_pkg::OP_REL) ? (pos_ff + rtgt_ff) : rtgt_ff;
   assign move_d    = move_tgt - pos_ff;

   always_comb begin
      if (rem == PW'(0)) begin
         cur_phase = stp_pkg::PH_IDLE;
      end else if (rem32 <= decel_ff) begin
         cur_phase = stp_pkg::PH_DECEL;
      end else if (vel_ff >= cruise_ff) begin
         cur_phase = stp_pkg::PH_CRUISE;
      end else begin
         cur_phase = stp_pkg::PH_ACCEL;
      end
   end

   assign vdiff  = (pk_ff >= ev_ff) ? (pk_ff - ev_ff) : (ev_ff - pk_ff);
   assign vsq_op = (op_ff == stp_pkg::OP_TICK) ? vel_ff : vdiff;

   // root operand: velocity squared plus or minus the step energy term
   assign base = {p1_ff, 8'd0};
   assign term = p2_ff[55:7];
   always_comb begin
      if (brn_ff == stp_pkg::PH_DECEL) begin
         radicand = (base >= 56'(term)) ? 64'(base - 56'(term)) : 64'd0;
      end else begin
         radicand = 64'(base) + 64'(term);
      end
   end

   assign num = (brn_ff == stp_pkg::PH_DECEL) ? (32'({vel_ff, 4'd0}) - root)
                                               : (root - 32'({vel_ff, 4'd0}));

   // divider operand select
   always_comb begin
      if (op_ff != stp_pkg::OP_TICK) begin
         dividend = {1'b0, p1_ff, 15'd0};
         divisor  = 64'(p2_ff);
      end else if (brn_ff == stp_pkg::PH_CRUISE) begin
         dividend = 64'(p3_ff);
         divisor  = 64'({eff_pk, 16'd0});
      end else begin
         dividend = 64'(p4_ff);
         divisor  = 64'({eff_acc, 4'd0});
      end
   end

   assign q_sat = (quotient[63:32] != 32'd0) ? 32'hFFFF_FFFF : quotient[31:0];

   stp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .root     (root)
   );

   stp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign status.op        = op_ff;
   assign status.due       = due;
   assign status.go        = move_d != PW'(0);
   assign status.branch    = brn_ff;
   assign status.sqrt_busy = sqrt_busy;
   assign status.div_busy  = div_busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= stp_pkg::STEP_LENGTH_RST;
         acc_ff <= stp_pkg::ACCELERATION_RST;
         inv_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            stp_pkg::CSR_STEP_LENGTH:  len_ff <= csr_wdata[23:0];
            stp_pkg::CSR_ACCELERATION: acc_ff <= csr_wdata;
            stp_pkg::CSR_INVERT:       inv_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // latch the request
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_op;
         rtgt_ff <= req_step_target[PW-1:0];
         sv_ff   <= req_start_velocity;
         ev_ff   <= req_end_velocity;
         pk_ff   <= req_peak_velocity;
      end
   end

   // products, one register after each
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         p1_ff <= vsq_op * vsq_op;
         p2_ff <= eff_acc * eff_len;
         p3_ff <= eff_len * stp_pkg::US_PER_S;
      end
      if (cmd.mul2) begin
         p4_ff <= num * stp_pkg::US_PER_S;
      end
   end

   // motion state update
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         tgt_ff    <= '0;
         neg_ff    <= 1'b0;
         dir_ff    <= 1'b0;
         time_ff   <= 32'd0;
         nst_ff    <= 32'd0;
         vel_ff    <= 24'd0;
         cruise_ff <= 24'd0;
         decel_ff  <= 32'd0;
         brn_ff    <= stp_pkg::PH_IDLE;
         pulse_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            pulse_ff <= 1'b0;
         end
         if (cmd.exec) begin
            unique case (op_ff)
               stp_pkg::OP_TICK: begin
                  time_ff <= time_n;
                  if (due) begin
                     pulse_ff <= 1'b1;
                     brn_ff   <= cur_phase;
                     pos_ff   <= neg_ff ? (pos_ff - PW'(1)) : (pos_ff + PW'(1));
                  end
               end
               stp_pkg::OP_ABS, stp_pkg::OP_REL: begin
                  if (move_d != PW'(0)) begin
                     neg_ff    <= move_d[PW-1];
                     dir_ff    <= move_d[PW-1] ^ inv_ff;
                     nst_ff    <= time_ff;
                     vel_ff    <= sv_ff;
                     cruise_ff <= pk_ff;
                     tgt_ff    <= move_tgt;
                  end
               end
               stp_pkg::OP_ZERO: pos_ff <= '0;
               default: ;
            endcase
         end
         // new velocity from the root, saturated
         if (cmd.mul2) begin
            vel_ff <= (root[31:28] != 4'd0) ? 24'hFF_FFFF : root[27:4];
         end
         if (cmd.commit) begin
            if (op_ff != stp_pkg::OP_TICK) begin
               decel_ff <= q_sat;
            end else begin
               nst_ff <= nst_ff + q_sat;
               if (brn_ff == stp_pkg::PH_CRUISE) begin
                  vel_ff <= cruise_ff;
               end
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_pulse_ff  <= pulse_ff;
         o_dir_ff    <= dir_ff;
         o_pos_ff    <= pos_ff;
         o_moving_ff <= rem != PW'(0);
         o_phase_ff  <= cur_phase;
      end
   end

   assign rsp_step_pulse = o_pulse_ff;
   assign rsp_dir_level  = o_dir_ff;
   assign rsp_position   = 32'(signed'(o_pos_ff));
   assign rsp_moving     = o_moving_ff;
   assign rsp_phase      = o_phase_ff;

endmodule

@@ hdl/stp_ctrl.sv @@
`timescale 1ns / 1ps
module stp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  stp_pkg::status_type status,
   output stp_pkg::cmd_type    cmd,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_SQRT  = 4'd3;
   localparam logic [3:0] S_SQRTW = 4'd4;
   localparam logic [3:0] S_MUL2  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_DIVW  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // sequence the work of one request
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            priority if (status.op == stp_pkg::OP_TICK) begin
               state_in = status.due ? S_MUL : S_DONE;
            end else if (status.op == stp_pkg::OP_ZERO) begin
               state_in = S_DONE;
            end else begin
               state_in = status.go ? S_MUL : S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            if (status.op == stp_pkg::OP_TICK && status.branch != stp_pkg::PH_CRUISE) begin
               state_in = S_SQRT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQRTW;
         end
         S_SQRTW: begin
            if (!status.sqrt_busy) state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (!status.div_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold the result until taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/stepper_trapezoid_profile.sv @@
`timescale 1ns / 1ps
// Trapezoidal step generator, one request at a time. A tick that issues no
// step, a zero request and a move to the current position skip the arithmetic;
// a move runs a 64-bit divide for the deceleration step count; a tick that
// issues a step runs the divide for the step delay, preceded while accelerating
// or decelerating by the iterative square root for the new velocity. The next
// request is taken while a finished response waits.
module stepper_trapezoid_profile #(
   parameter int POSITION_WIDTH = stp_pkg::POSITION_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_step_target,
   input  logic [23:0]        req_start_velocity,
   input  logic [23:0]        req_end_velocity,
   input  logic [23:0]        req_peak_velocity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_step_pulse,
   output logic               rsp_dir_level,
   output logic signed [31:0] rsp_position,
   output logic               rsp_moving,
   output logic [1:0]         rsp_phase,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   stp_pkg::cmd_type    cmd;
   stp_pkg::status_type status;

   stp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   stp_dp #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_step_target    (req_step_target),
      .req_start_velocity (req_start_velocity),
      .req_end_velocity   (req_end_velocity),
      .req_peak_velocity  (req_peak_velocity),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_step_pulse     (rsp_step_pulse),
      .rsp_dir_level      (rsp_dir_level),
      .rsp_position       (rsp_position),
      .rsp_moving         (rsp_moving),
      .rsp_phase          (rsp_phase)
   );

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   // root and divide units never overlap
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(status.sqrt_busy && status.div_busy))
      else $error("root and divide busy together");

   // a response that is not moving reports idle
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_moving) |-> (rsp_phase == stp_pkg::PH_IDLE))
      else $error("phase not idle while stopped");

endmodule

@@ sim/tb_stepper_trapezoid_profile.sv @@
`timescale 1ns / 1ps
module tb_stepper_trapezoid_profile;

   typedef struct packed {
      bit        pulse;
      bit        dir;
      bit [31:0] pos;
      bit        moving;
      bit [1:0]  phase;
   } step_report_type;

   typedef struct {
      logic [1:0]      op;
      logic [31:0]     target;
      logic [23:0]     v_start;
      logic [23:0]     v_end;
      logic [23:0]     v_peak;
      bit              typed;
      step_report_type want;
   } request_row_type;

   localparam int STALL_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = stp_pkg::OP_TICK;
   logic signed [31:0] req_step_target = '0;
   logic [23:0]        req_start_velocity = '0;
   logic [23:0]        req_end_velocity = '0;
   logic [23:0]        req_peak_velocity = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_step_pulse;
   logic               rsp_dir_level;
   logic signed [31:0] rsp_position;
   logic               rsp_moving;
   logic [1:0]         rsp_phase;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = stp_pkg::CSR_STEP_LENGTH;
   logic [31:0]        csr_wdata = '0;

   // profile state mirror
   bit [23:0] pf_len;
   bit [31:0] pf_accel;
   bit        pf_invert;
   bit [31:0] pf_pos, pf_target, pf_clock, pf_due, pf_decel;
   bit        pf_negative, pf_dir;
   bit [23:0] pf_vel, pf_cruise;

   step_report_type pending_reports[$];
   int  error_count = 0;
   int  request_count = 0;
   int  pulse_count = 0;
   int  idle_cycles = 0;
   bit  no_idling = 1'b0;

   stepper_trapezoid_profile u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned isqrt_floor(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic bit [31:0] clip32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic bit [31:0] steps_left();
      bit [31:0] d;
      d = pf_target - pf_pos;
      if (d[31]) d = -d;
      return d;
   endfunction

   // schedule the next step time after a step
   function automatic void plan_next_step(bit [31:0] left);
      longint unsigned a, s, u, base, term, q, num, dly, p;
      a = (pf_accel != 0) ? 64'(pf_accel) : 64'd1;
      s = (pf_len != 0) ? 64'(pf_len) : 64'd1;
      u = 64'(pf_vel);
      base = (u * u) << 8;
      term = (64'd2 * a * s) >> 8;
      if (left <= pf_decel) begin
         q = isqrt_floor(base >= term ? base - term : 64'd0);
         num = 64'd16 * u - q;
         dly = num * 64'd1000000 / (64'd16 * a);
      end else if (u >= 64'(pf_cruise)) begin
         p = (pf_cruise != 0) ? 64'(pf_cruise) : 64'd1;
         pf_vel = pf_cruise;
         pf_due += clip32(s * 64'd1000000 / (p << 16));
         return;
      end else begin
         q = isqrt_floor(base + term);
         num = q - 64'd16 * u;
         dly = num * 64'd1000000 / (64'd16 * a);
      end
      q >>= 4;
      pf_vel = (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
      pf_due += clip32(dly);
   endfunction

   function automatic void launch_move(bit [31:0] goal, bit [23:0] sv, bit [23:0] ev,
                                       bit [23:0] pk);
      bit [31:0] d;
      longint unsigned diff, den;
      d = goal - pf_pos;
      if (d == 0) return;
      pf_negative = d[31];
      pf_dir = pf_negative ^ pf_invert;
      pf_due = pf_clock;
      pf_vel = sv;
      pf_cruise = pk;
      diff = (pk >= ev) ? 64'(pk - ev) : 64'(ev - pk);
      den = ((pf_accel != 0) ? 64'(pf_accel) : 64'd1) * ((pf_len != 0) ? 64'(pf_len) : 64'd1);
      pf_decel = clip32(((diff * diff) << 15) / den);
      pf_target = goal;
   endfunction

   function automatic step_report_type predict_step(request_row_type r);
      step_report_type o;
      bit [31:0] left, lag;
      o = '0;
      case (r.op)
         stp_pkg::OP_TICK: begin
            pf_clock += 1;
            left = steps_left();
            lag = pf_clock - pf_due;
            if (left != 0 && !lag[31]) begin
               o.pulse = 1'b1;
               pf_pos = pf_negative ? pf_pos - 1 : pf_pos + 1;
               plan_next_step(left);
            end
         end
         stp_pkg::OP_ABS: launch_move(r.target, r.v_start, r.v_end, r.v_peak);
         stp_pkg::OP_REL: launch_move(pf_pos + r.target, r.v_start, r.v_end, r.v_peak);
         default:         pf_pos = '0;
      endcase
      left = steps_left();
      o.dir = pf_dir;
      o.pos = pf_pos;
      o.moving = (left != 0);
      if (left == 0) o.phase = stp_pkg::PH_IDLE;
      else if (left <= pf_decel) o.phase = stp_pkg::PH_DECEL;
      else if (pf_vel >= pf_cruise) o.phase = stp_pkg::PH_CRUISE;
      else o.phase = stp_pkg::PH_ACCEL;
      return o;
   endfunction

   // drive one request, hold until taken, then record the expected report
   task automatic send_request(request_row_type r);
      step_report_type o;
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= r.op;
      req_step_target <= r.target;
      req_start_velocity <= r.v_start;
      req_end_velocity <= r.v_end;
      req_peak_velocity <= r.v_peak;
      do @(posedge clock); while (req_stall);
      o = predict_step(r);
      pending_reports.push_back(r.typed ? r.want : o);
      request_count++;
      if (!no_idling && $urandom_range(99) < 37) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         stp_pkg::CSR_STEP_LENGTH:  pf_len = val[23:0];
         stp_pkg::CSR_ACCELERATION: pf_accel = val;
         default:                   pf_invert = val[0];
      endcase
   endtask

   function automatic request_row_type random_request();
      request_row_type r;
      int pick;
      r.typed = 1'b0;
      r.want = '0;
      r.target = $urandom;
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) begin
         r.v_start = 24'($urandom_range(0, 24'hFF_FFFF));
         r.v_end = 24'($urandom_range(0, 24'hFF_FFFF));
         r.v_peak = 24'($urandom_range(0, 24'hFF_FFFF));
      end else begin
         r.v_start = 24'($urandom_range(0, 60000));
         r.v_end = 24'($urandom_range(0, 60000));
         r.v_peak = 24'($urandom_range(1000, 400000));
      end
      if (pick < 80) begin
         r.op = stp_pkg::OP_TICK;
      end else if (pick < 90) begin
         r.op = stp_pkg::OP_REL;
         r.target = $signed($urandom_range(1, 40)) * ($urandom_range(1) ? 1 : -1);
      end else if (pick < 95) begin
         r.op = stp_pkg::OP_ABS;
         if ($urandom_range(1)) r.target = pf_pos + $urandom_range(0, 30) - 15;
      end else if (pick < 97) begin
         r.op = stp_pkg::OP_REL;
      end else begin
         r.op = stp_pkg::OP_ZERO;
      end
      return r;
   endfunction

   // directed rows: typed expectations only where obvious after reset
   request_row_type directed[] = '{
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b1,
        '{0, 0, 32'd0, 0, stp_pkg::PH_IDLE}},
      '{stp_pkg::OP_ZERO, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1,
        '{0, 0, 32'd0, 0, stp_pkg::PH_IDLE}},
      '{stp_pkg::OP_ABS, 32'd0, 24'd100, 24'd0, 24'd5000, 1'b1,
        '{0, 0, 32'd0, 0, stp_pkg::PH_IDLE}},
      '{stp_pkg::OP_REL, 32'd5, 24'd0, 24'd0, 24'hFF_FFFF, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_REL, -32'sd3, 24'hFF_FFFF, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_ZERO, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_ABS, 32'h7FFF_FFFF, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_ABS, 32'h8000_0000, 24'd0, 24'hFF_FFFF, 24'd0, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_ABS, 32'd2, 24'd0, 24'hFF_FFFF, 24'd0, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'd0, 24'd0, 24'd0, 24'd1, 1'b0, '0},
      '{stp_pkg::OP_TICK, 32'hFFFF_FFFF, 24'd0, 24'd0, 24'd1, 1'b0, '0}
   };

   // result stall pattern
   always @(negedge clock) begin
      rsp_stall <= no_idling ? 1'b0 : ($urandom_range(99) < 37);
   end

   // compare each report with the oldest expectation; watch for a hang
   always @(posedge clock) begin
      step_report_type w;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_stepper_trapezoid_profile: done, errors");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected report");
               error_count++;
            end else begin
               w = pending_reports.pop_front();
               if (rsp_step_pulse) pulse_count++;
               if (rsp_step_pulse !== w.pulse) begin
                  $error("step_pulse: expected %0d got %0d", w.pulse, rsp_step_pulse);
                  error_count++;
               end
               if (rsp_dir_level !== w.dir) begin
                  $error("dir_level: expected %0d got %0d", w.dir, rsp_dir_level);
                  error_count++;
               end
               if (rsp_position !== w.pos) begin
                  $error("position: expected %0d got %0d", $signed(w.pos), rsp_position);
                  error_count++;
               end
               if (rsp_moving !== w.moving) begin
                  $error("moving: expected %0d got %0d", w.moving, rsp_moving);
                  error_count++;
               end
               if (rsp_phase !== w.phase) begin
                  $error("phase: expected %0d got %0d", w.phase, rsp_phase);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      logic [23:0] lens[5];
      logic [31:0] accels[5];
      pf_len = stp_pkg::STEP_LENGTH_RST;
      pf_accel = stp_pkg::ACCELERATION_RST;
      pf_invert = 1'b0;
      {pf_pos, pf_target, pf_clock, pf_due, pf_decel} = '0;
      {pf_negative, pf_dir, pf_vel, pf_cruise} = '0;
      lens = '{stp_pkg::STEP_LENGTH_RST, 24'hFF_FFFF, 24'd1, 24'd100000, 24'd0};
      accels = '{stp_pkg::ACCELERATION_RST, 32'hFFFF_FFFF, 32'd1, 32'd50000000, 32'd0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_request(directed[i]);
      drain();

      // random phases over several register settings
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 4) begin
            lens[4] = 24'($urandom_range(1, 24'hFF_FFFF));
            accels[4] = $urandom_range(1000, 32'h7FFF_FFFF);
         end
         write_reg(stp_pkg::CSR_STEP_LENGTH, lens[ph]);
         write_reg(stp_pkg::CSR_ACCELERATION, accels[ph]);
         write_reg(stp_pkg::CSR_INVERT, 32'(ph % 2));
         no_idling = (ph == 3);
         for (int k = 0; k < 216; k++) begin
            send_request(random_request());
            // hold the sender until every report is in
            if (k == 100) drain();
         end
         drain();
      end
      no_idling = 1'b0;

      repeat (200) @(posedge clock);
      $display("run: %0d requests over five register settings, %0d step pulses seen",
               request_count, pulse_count);
      if (error_count == 0) begin
         $display("tb_stepper_trapezoid_profile: done, clean");
      end else begin
         $display("tb_stepper_trapezoid_profile: done, errors");
      end
      $finish;
   end

endmodule
